>>> design/filmic_tone_map_grade_defines.svh
// assertion macros for the filmic tone map and grade block
`ifndef FILMIC_TONE_MAP_GRADE_DEFINES_SVH
`define FILMIC_TONE_MAP_GRADE_DEFINES_SVH

// same-cycle implication, checked out of reset
`define FMTM_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("fmtm check failed");

// next-cycle implication, checked out of reset
`define FMTM_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("fmtm check failed");

`endif

>>> design/fmtm_pkg.sv
// constants, types and gamma table for the filmic tone map and grade block
package fmtm_pkg;

  localparam int GAMMA_TABLE_SIZE     = 256;
  localparam int OUTPUT_FRACTION_BITS = 16;

  localparam int IN_W   = 24;
  localparam int GAIN_W = 16;
  localparam int OUT_W  = OUTPUT_FRACTION_BITS;
  localparam int T_W    = 17;
  localparam int KW     = $clog2(GAMMA_TABLE_SIZE);
  localparam int P_W    = T_W + KW;

  localparam int LG_FRAC = 24;

  localparam logic [17:0] K251 = 18'd164495;
  localparam logic [10:0] K003 = 11'd1966;
  localparam logic [17:0] K243 = 18'd159252;
  localparam logic [15:0] K059 = 16'd38666;
  localparam logic [13:0] K014 = 14'd9175;

  localparam logic [15:0] LUM_R = 16'd13933;
  localparam logic [15:0] LUM_G = 16'd46871;
  localparam logic [15:0] LUM_B = 16'd4732;

  localparam int FILM_LAT  = 22;
  localparam int MERGE_LAT = 2;
  localparam int GRADE_LAT = 8;
  localparam int PIPE_LAT  = FILM_LAT + MERGE_LAT + GRADE_LAT;

  localparam int UP     = (OUTPUT_FRACTION_BITS >= 16) ? OUTPUT_FRACTION_BITS - 16 : 0;
  localparam int DN     = (OUTPUT_FRACTION_BITS < 16) ? 16 - OUTPUT_FRACTION_BITS : 0;
  localparam int GS_W   = T_W + UP + 1;
  localparam int RND    = (1 << DN) >> 1;

  typedef logic [1:0] cfg_index_t;
  localparam cfg_index_t REG_EXPOSURE   = 2'd0;
  localparam cfg_index_t REG_SATURATION = 2'd1;
  localparam cfg_index_t REG_CONTRAST   = 2'd2;

  typedef logic [T_W-1:0] gamma_tab_t [GAMMA_TABLE_SIZE];

  // log2 with LG_FRAC fraction bits by repeated squaring
  function automatic longint int_log2(input longint n);
    longint v;
    longint r;
    int     msb;
    int     i;
    msb = 0;
    while (msb < 31 && (n >> (msb + 1)) != 0) msb++;
    v = n << (30 - msb);
    r = longint'(msb);
    for (i = 0; i < LG_FRAC; i++) begin
      v = (v * v) >> 30;
      r = r * 2;
      if (v >= (longint'(1) << 31)) begin
        r = r + 1;
        v = v >> 1;
      end
    end
    return r;
  endfunction

  // x^0.94 samples, largest y meeting the log bound, found by binary search
  function automatic gamma_tab_t build_gamma();
    gamma_tab_t tab;
    longint     lg_top;
    longint     rhs;
    longint     lhs;
    longint     lo;
    longint     hi;
    longint     mid;
    int         i;
    lg_top = int_log2(longint'(GAMMA_TABLE_SIZE - 1));
    tab[0] = '0;
    for (i = 1; i < GAMMA_TABLE_SIZE; i++) begin
      rhs = 47 * (int_log2(longint'(i)) - lg_top);
      lo  = 0;
      hi  = 65536;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        lhs = 50 * (int_log2(mid) - (longint'(16) << LG_FRAC));
        if (lhs <= rhs) lo = mid;
        else hi = mid - 1;
      end
      tab[i] = T_W'(lo);
    end
    return tab;
  endfunction

  localparam gamma_tab_t GAMMA_TAB = build_gamma();

endpackage

>>> design/fmtm_filmic.sv
// one channel lane: clamp, exposure, filmic curve with a pipelined divider
module fmtm_filmic import fmtm_pkg::*; (
  input  logic                     clk,
  input  logic signed [IN_W-1:0]   x,
  input  logic        [GAIN_W-1:0] gain,
  output logic        [T_W-1:0]    t
);

  localparam int E_W   = 25;
  localparam int PR_W  = 39;
  localparam int PK_W  = 43;
  localparam int M_W   = 27;
  localparam int N_W   = 52;
  localparam int D_W   = 37;
  localparam int TR_W  = N_W + 2;

  logic [IN_W-2:0] xc;
  logic [PR_W-1:0] prod1;
  logic [E_W-1:0]  e2;
  logic [E_W-1:0]  e3;
  logic [PK_W-1:0] p251;
  logic [PK_W-1:0] p243;
  logic [M_W-1:0]  m1;
  logic [M_W-1:0]  m2;
  logic [N_W-1:0]  num4;
  logic [N_W-1:0]  den4;
  logic [N_W-1:0]  num5;
  logic [D_W-1:0]  d5;

  logic [N_W-1:0]  rem_s [T_W];
  logic [D_W-1:0]  d_s   [T_W];
  logic [T_W-1:0]  q_s   [T_W];
  logic [N_W-1:0]  rem_in [T_W];
  logic [D_W-1:0]  d_in   [T_W];
  logic [T_W-1:0]  q_in   [T_W];
  logic [N_W-1:0]  rem_next [T_W];
  logic [T_W-1:0]  q_next   [T_W];
  logic [TR_W-1:0] trial    [T_W];

  assign xc = x[IN_W-1] ? '0 : x[IN_W-2:0];
  assign m1 = M_W'((p251 + PK_W'(32768)) >> 16) + M_W'(K003);
  assign m2 = M_W'((p243 + PK_W'(32768)) >> 16) + M_W'(K059);

  always_ff @(posedge clk) begin
    prod1 <= PR_W'(xc) * PR_W'(gain);
    e2    <= E_W'((prod1 + PR_W'(8192)) >> 14);
    e3    <= e2;
    p251  <= PK_W'(K251) * PK_W'(e2);
    p243  <= PK_W'(K243) * PK_W'(e2);
    num4  <= N_W'(e3) * N_W'(m1);
    den4  <= N_W'(e3) * N_W'(m2);
    num5  <= num4;
    d5    <= D_W'(((N_W + 1)'(den4) + ((N_W + 1)'(K014) << 16)) >> 16);
  end

  // restoring division, one quotient bit per stage, msb first
  always_comb begin
    for (int s = 0; s < T_W; s++) begin
      rem_in[s] = (s == 0) ? num5 : rem_s[(s == 0) ? 0 : s - 1];
      d_in[s]   = (s == 0) ? d5 : d_s[(s == 0) ? 0 : s - 1];
      q_in[s]   = (s == 0) ? '0 : q_s[(s == 0) ? 0 : s - 1];
      trial[s]  = TR_W'(rem_in[s]) - (TR_W'(d_in[s]) << (T_W - 1 - s));
      if (!trial[s][TR_W-1]) begin
        rem_next[s] = trial[s][N_W-1:0];
        q_next[s]   = {q_in[s][T_W-2:0], 1'b1};
      end else begin
        rem_next[s] = rem_in[s];
        q_next[s]   = {q_in[s][T_W-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < T_W; s++) begin
      rem_s[s] <= rem_next[s];
      d_s[s]   <= d_in[s];
      q_s[s]   <= q_next[s];
    end
  end

  assign t = q_s[T_W-1];

endmodule

>>> design/fmtm_grade.sv
// one channel lane: saturation, contrast, clamp and interpolated gamma
module fmtm_grade import fmtm_pkg::*; (
  input  logic              clk,
  input  logic [T_W-1:0]    t,
  input  logic [T_W-1:0]    lum,
  input  logic [GAIN_W-1:0] sat_gain,
  input  logic [GAIN_W-1:0] con_gain,
  output logic [OUT_W-1:0]  y
);

  localparam int SP_W = 35;
  localparam int S_W  = 23;
  localparam int CP_W = 41;
  localparam int V_W  = 28;

  logic signed [T_W:0]    diff;
  logic signed [SP_W-1:0] prod1;
  logic        [T_W-1:0]  lum1;
  logic signed [S_W-1:0]  s_val;
  logic signed [S_W-1:0]  s2;
  logic signed [S_W:0]    sc;
  logic signed [CP_W-1:0] cp;
  logic signed [V_W-1:0]  v;
  logic        [T_W-1:0]  c4;
  logic        [P_W-1:0]  p;
  logic        [KW-1:0]   k5;
  logic        [15:0]     f5;
  logic        [KW-1:0]   k_up;
  logic        [T_W-1:0]  lo6;
  logic        [T_W-1:0]  dlt6;
  logic        [15:0]     f6;
  logic        [T_W-1:0]  hi_v;
  logic        [T_W-1:0]  g7;
  logic        [GS_W-1:0] gs;
  logic        [GS_W-1:0] gr;

  assign diff  = $signed({1'b0, t}) - $signed({1'b0, lum});
  assign s_val = $signed(S_W'(lum1)) + S_W'((prod1 + SP_W'(8192)) >>> 14);
  assign sc    = (S_W + 1)'(s2) - (S_W + 1)'(32768);
  assign v     = V_W'((cp + CP_W'(8192)) >>> 14) + V_W'(32768);
  assign p     = P_W'(c4) * P_W'(GAMMA_TABLE_SIZE - 1);
  assign k_up  = k5 + KW'(1);
  // top entry has no right neighbor, and its fraction is always zero there
  assign hi_v  = (k5 == KW'(GAMMA_TABLE_SIZE - 1)) ? GAMMA_TAB[k5] : GAMMA_TAB[k_up];
  assign gs    = GS_W'(g7) << UP;
  assign gr    = (gs + GS_W'(RND)) >> DN;

  always_ff @(posedge clk) begin
    prod1 <= SP_W'(diff) * SP_W'($signed({1'b0, sat_gain}));
    lum1  <= lum;
    s2    <= s_val;
    cp    <= CP_W'(sc) * CP_W'($signed({1'b0, con_gain}));
    if (v < 0) begin
      c4 <= '0;
    end else if (v > V_W'(65536)) begin
      c4 <= T_W'(65536);
    end else begin
      c4 <= v[T_W-1:0];
    end
    k5    <= p[16+KW-1:16];
    f5    <= p[15:0];
    lo6   <= GAMMA_TAB[k5];
    dlt6  <= hi_v - GAMMA_TAB[k5];
    f6    <= f5;
    g7    <= lo6 + T_W'(((T_W + 17)'(dlt6) * (T_W + 17)'(f6) + (T_W + 17)'(32768)) >> 16);
    if (gr > GS_W'((1 << OUT_W) - 1)) begin
      y <= '1;
    end else begin
      y <= gr[OUT_W-1:0];
    end
  end

endmodule

>>> design/filmic_tone_map_grade.sv
// top level: three filmic lanes, luminance merge, three grade lanes
// One pixel is taken in every clock while start is high; busy is only high
// during reset. Each pixel comes out in the order taken, marked by done for one
// cycle, after the 17-stage quotient pipeline of the filmic curve, plus the
// exposure and curve multiplies, a two-stage luminance merge and an eight-stage
// grade and gamma lookup. There is no back-pressure: results must be taken when
// done is high. Gain registers should be written only when no pixel is in flight.
module filmic_tone_map_grade import fmtm_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  output logic                     busy,
  input  logic signed [IN_W-1:0]   red_in,
  input  logic signed [IN_W-1:0]   green_in,
  input  logic signed [IN_W-1:0]   blue_in,
  output logic                     done,
  output logic        [OUT_W-1:0]  red_out,
  output logic        [OUT_W-1:0]  green_out,
  output logic        [OUT_W-1:0]  blue_out,
  input  logic                     cfg_we,
  input  cfg_index_t               cfg_index,
  input  logic        [GAIN_W-1:0] cfg_data
);

`include "filmic_tone_map_grade_defines.svh"

  localparam int LP_W = 33;
  localparam int LS_W = 35;

  logic [GAIN_W-1:0]   exposure_gain;
  logic [GAIN_W-1:0]   saturation_gain;
  logic [GAIN_W-1:0]   contrast_gain;
  logic [PIPE_LAT-1:0] vld;
  logic                accept;

  logic [T_W-1:0]  tr;
  logic [T_W-1:0]  tg;
  logic [T_W-1:0]  tb;
  logic [T_W-1:0]  tr1;
  logic [T_W-1:0]  tg1;
  logic [T_W-1:0]  tb1;
  logic [T_W-1:0]  tr2;
  logic [T_W-1:0]  tg2;
  logic [T_W-1:0]  tb2;
  logic [LP_W-1:0] pr;
  logic [LP_W-1:0] pg;
  logic [LP_W-1:0] pb;
  logic [T_W-1:0]  lum;

  assign busy   = rst;
  assign accept = start && !busy;
  assign done   = vld[PIPE_LAT-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      exposure_gain   <= GAIN_W'(20480);
      saturation_gain <= GAIN_W'(18350);
      contrast_gain   <= GAIN_W'(17695);
      vld             <= '0;
    end else begin
      vld <= {vld[PIPE_LAT-2:0], accept};
      if (cfg_we) begin
        case (cfg_index)
          REG_EXPOSURE:   exposure_gain   <= cfg_data;
          REG_SATURATION: saturation_gain <= cfg_data;
          REG_CONTRAST:   contrast_gain   <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  fmtm_filmic u_film_r (.clk(clk), .x(red_in),   .gain(exposure_gain), .t(tr));
  fmtm_filmic u_film_g (.clk(clk), .x(green_in), .gain(exposure_gain), .t(tg));
  fmtm_filmic u_film_b (.clk(clk), .x(blue_in),  .gain(exposure_gain), .t(tb));

  // rec.709 luminance of the curved channels
  always_ff @(posedge clk) begin
    pr  <= LP_W'(LUM_R) * LP_W'(tr);
    pg  <= LP_W'(LUM_G) * LP_W'(tg);
    pb  <= LP_W'(LUM_B) * LP_W'(tb);
    tr1 <= tr;
    tg1 <= tg;
    tb1 <= tb;
    lum <= T_W'((LS_W'(pr) + LS_W'(pg) + LS_W'(pb) + LS_W'(32768)) >> 16);
    tr2 <= tr1;
    tg2 <= tg1;
    tb2 <= tb1;
  end

  fmtm_grade u_grade_r (.clk(clk), .t(tr2), .lum(lum), .sat_gain(saturation_gain),
                        .con_gain(contrast_gain), .y(red_out));
  fmtm_grade u_grade_g (.clk(clk), .t(tg2), .lum(lum), .sat_gain(saturation_gain),
                        .con_gain(contrast_gain), .y(green_out));
  fmtm_grade u_grade_b (.clk(clk), .t(tb2), .lum(lum), .sat_gain(saturation_gain),
                        .con_gain(contrast_gain), .y(blue_out));

  `FMTM_ASSERT_NOW(a_done_latency, done, $past(accept, PIPE_LAT))
  `FMTM_ASSERT_NEXT(a_exp_write, cfg_we && cfg_index == REG_EXPOSURE, exposure_gain == $past(cfg_data))
  `FMTM_ASSERT_NEXT(a_con_write, cfg_we && cfg_index == REG_CONTRAST, contrast_gain == $past(cfg_data))
  `FMTM_ASSERT_NEXT(a_no_write, !cfg_we, $stable(saturation_gain) && $stable(exposure_gain))

endmodule

>>> bench/tb_filmic_tone_map_grade.sv
// self-checking testbench for the filmic tone map and grade block
`timescale 1ns / 100ps

module tb_filmic_tone_map_grade;
  import fmtm_pkg::*;

  typedef struct packed {
    logic signed [IN_W-1:0] r;
    logic signed [IN_W-1:0] g;
    logic signed [IN_W-1:0] b;
  } pixel_t;

  typedef struct packed {
    logic [OUT_W-1:0] r;
    logic [OUT_W-1:0] g;
    logic [OUT_W-1:0] b;
  } graded_t;

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic signed [IN_W-1:0] red_in, green_in, blue_in;
  logic done;
  logic [OUT_W-1:0] red_out, green_out, blue_out;
  logic cfg_we;
  cfg_index_t cfg_index;
  logic [GAIN_W-1:0] cfg_data;

  filmic_tone_map_grade dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .red_in(red_in), .green_in(green_in), .blue_in(blue_in),
    .done(done), .red_out(red_out), .green_out(green_out), .blue_out(blue_out),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  pixel_t  pixel_q[$];
  graded_t graded_q[$];
  longint  curve_tab[GAMMA_TABLE_SIZE];
  longint  exp_gain, sat_gain, con_gain;
  bit      no_idle;
  int      fail_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // fixed-point log2 with 24 fraction bits, by squaring the mantissa
  function automatic longint fx_log2(longint n);
    longint m;
    longint acc;
    int     top;
    top = 0;
    while (top < 31 && (n >> (top + 1)) != 0) top++;
    m = n << (30 - top);
    acc = top;
    repeat (24) begin
      m = (m * m) >> 30;
      acc = acc * 2;
      if (m >= (longint'(1) << 31)) begin
        acc = acc + 1;
        m = m >> 1;
      end
    end
    return acc;
  endfunction

  function automatic longint tone_curve(logic signed [IN_W-1:0] raw);
    longint x, e, num, den;
    x = (raw < 0) ? 0 : longint'(raw);
    e = (x * exp_gain + 8192) >> 14;
    num = e * (((longint'(K251) * e + 32768) >> 16) + longint'(K003));
    den = e * (((longint'(K243) * e + 32768) >> 16) + longint'(K059))
          + (longint'(K014) << 16);
    return num / (den >> 16);
  endfunction

  function automatic logic [OUT_W-1:0] grade_channel(longint t, longint lum);
    longint s, c, p, k, f, g, lim;
    s = lum + (((t - lum) * sat_gain + 8192) >>> 14);
    c = (((s - 32768) * con_gain + 8192) >>> 14) + 32768;
    if (c < 0) c = 0;
    if (c > 65536) c = 65536;
    p = c * (GAMMA_TABLE_SIZE - 1);
    k = p >> 16;
    f = p & 16'hFFFF;
    if (k >= GAMMA_TABLE_SIZE - 1) g = curve_tab[GAMMA_TABLE_SIZE - 1];
    else g = curve_tab[k] + (((curve_tab[k + 1] - curve_tab[k]) * f + 32768) >> 16);
    if (OUT_W < 16) g = (g + (longint'(1) << (15 - OUT_W))) >> (16 - OUT_W);
    else g = g << (OUT_W - 16);
    lim = (longint'(1) << OUT_W) - 1;
    return (g > lim) ? lim[OUT_W-1:0] : g[OUT_W-1:0];
  endfunction

  function automatic graded_t grade_pixel(pixel_t px);
    longint tr, tg, tb, lum;
    graded_t res;
    tr = tone_curve(px.r);
    tg = tone_curve(px.g);
    tb = tone_curve(px.b);
    lum = (longint'(LUM_R) * tr + longint'(LUM_G) * tg + longint'(LUM_B) * tb + 32768) >> 16;
    res.r = grade_channel(tr, lum);
    res.g = grade_channel(tg, lum);
    res.b = grade_channel(tb, lum);
    return res;
  endfunction

  // driver: holds a beat until start && !busy takes it
  always @(posedge clk) begin
    pixel_t px;
    if (rst) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) graded_q.push_back(grade_pixel('{red_in, green_in, blue_in}));
      if (!(start && busy)) begin
        if (pixel_q.size() != 0 && (no_idle || $urandom_range(99) >= 6)) begin
          px = pixel_q.pop_front();
          start <= 1'b1;
          red_in <= px.r;
          green_in <= px.g;
          blue_in <= px.b;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    graded_t want;
    if (!rst && done) begin
      if (graded_q.size() == 0) begin
        $error("result beat with nothing expected");
        fail_count++;
      end else begin
        want = graded_q.pop_front();
        if (red_out !== want.r) begin
          $error("red_out expected %0d actual %0d", want.r, red_out);
          fail_count++;
        end
        if (green_out !== want.g) begin
          $error("green_out expected %0d actual %0d", want.g, green_out);
          fail_count++;
        end
        if (blue_out !== want.b) begin
          $error("blue_out expected %0d actual %0d", want.b, blue_out);
          fail_count++;
        end
      end
    end
  end

  task automatic write_gain(cfg_index_t idx, logic [GAIN_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_EXPOSURE:   exp_gain = val;
      REG_SATURATION: sat_gain = val;
      REG_CONTRAST:   con_gain = val;
      default: ;
    endcase
  endtask

  task automatic drain();
    do @(posedge clk); while (pixel_q.size() != 0 || start || graded_q.size() != 0);
    repeat (PIPE_LAT + 4) @(posedge clk);
  endtask

  function automatic logic signed [IN_W-1:0] rand_channel();
    int sel;
    sel = $urandom_range(99);
    if (sel < 65) return IN_W'($urandom_range(4 * 65536));
    if (sel < 80) return IN_W'($urandom);
    if (sel < 90) return IN_W'($urandom_range(2048));
    return -IN_W'($urandom_range(1 << (IN_W - 1)));
  endfunction

  task automatic queue_random(int n);
    repeat (n) pixel_q.push_back('{rand_channel(), rand_channel(), rand_channel()});
  endtask

  localparam logic signed [IN_W-1:0] MAXV = {1'b0, {(IN_W-1){1'b1}}};
  localparam logic signed [IN_W-1:0] MINV = {1'b1, {(IN_W-1){1'b0}}};
  localparam logic signed [IN_W-1:0] ONE  = 24'sd65536;

  initial begin
    longint top, rhs, lo, hi, mid;
    fail_count = 0;
    no_idle = 1'b0;
    rst = 1'b1;
    start = 1'b0;
    red_in = '0;
    green_in = '0;
    blue_in = '0;
    cfg_we = 1'b0;
    cfg_index = REG_EXPOSURE;
    cfg_data = '0;
    exp_gain = 20480;
    sat_gain = 18350;
    con_gain = 17695;
    // x^0.94 curve samples
    top = fx_log2(GAMMA_TABLE_SIZE - 1);
    curve_tab[0] = 0;
    for (int i = 1; i < GAMMA_TABLE_SIZE; i++) begin
      rhs = 47 * (fx_log2(i) - top);
      lo = 0;
      hi = 65536;
      while (lo < hi) begin
        mid = (lo + hi + 1) >> 1;
        if (50 * (fx_log2(mid) - (longint'(16) << 24)) <= rhs) lo = mid;
        else hi = mid - 1;
      end
      curve_tab[i] = lo;
    end
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // directed: extremes, negatives, mid grey, pure primaries
    pixel_q.push_back('{24'sd0, 24'sd0, 24'sd0});
    pixel_q.push_back('{MAXV, MAXV, MAXV});
    pixel_q.push_back('{MINV, MINV, MINV});
    pixel_q.push_back('{-24'sd1, -24'sd1, -24'sd1});
    pixel_q.push_back('{ONE, ONE, ONE});
    pixel_q.push_back('{24'sd32768, 24'sd32768, 24'sd32768});
    pixel_q.push_back('{ONE, 24'sd0, 24'sd0});
    pixel_q.push_back('{24'sd0, ONE, 24'sd0});
    pixel_q.push_back('{24'sd0, 24'sd0, ONE});
    pixel_q.push_back('{MAXV, MINV, 24'sd0});
    pixel_q.push_back('{MINV, 24'sd1, MAXV});
    pixel_q.push_back('{24'sd1, 24'sd1, 24'sd1});
    pixel_q.push_back('{24'sd8, -24'sd100, 24'sd65535});
    pixel_q.push_back('{24'sd1000000, 24'sd5000, 24'sd300});
    drain();
    write_gain(REG_EXPOSURE, 16'hFFFF);
    write_gain(REG_SATURATION, 16'hFFFF);
    write_gain(REG_CONTRAST, 16'hFFFF);
    pixel_q.push_back('{MAXV, MAXV, MAXV});
    pixel_q.push_back('{ONE, 24'sd0, 24'sd0});
    pixel_q.push_back('{24'sd4000, 24'sd20000, 24'sd100});
    drain();
    write_gain(REG_EXPOSURE, 16'h0000);
    write_gain(REG_SATURATION, 16'h0000);
    write_gain(REG_CONTRAST, 16'h0000);
    pixel_q.push_back('{ONE, MAXV, 24'sd0});
    pixel_q.push_back('{24'sd4000, 24'sd20000, 24'sd100});
    drain();

    // random phases at defaults, extremes and random gains
    write_gain(REG_EXPOSURE, 16'd20480);
    write_gain(REG_SATURATION, 16'd18350);
    write_gain(REG_CONTRAST, 16'd17695);
    queue_random(120);
    drain();
    no_idle = 1'b1;
    write_gain(REG_EXPOSURE, 16'hFFFF);
    write_gain(REG_CONTRAST, 16'd4096);
    queue_random(120);
    drain();
    no_idle = 1'b0;
    write_gain(REG_EXPOSURE, 16'd1024);
    write_gain(REG_SATURATION, 16'd0);
    write_gain(REG_CONTRAST, 16'hFFFF);
    queue_random(120);
    drain();
    repeat (3) begin
      write_gain(REG_EXPOSURE, GAIN_W'($urandom));
      write_gain(REG_SATURATION, GAIN_W'($urandom));
      write_gain(REG_CONTRAST, GAIN_W'($urandom));
      queue_random(80);
      drain();
    end

    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5000000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
